// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property violated");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/rps_pkg.sv =====
// shared types and constants of the relay peer selector
package rps_pkg;
	localparam int NODE_COUNT_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int MAX_NODES       = 64;

	localparam logic [2:0] CMD_UPDATE = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_QUERY  = 3'd2;
	localparam logic [2:0] CMD_FIND   = 3'd3;
	localparam logic [2:0] CMD_LIST   = 3'd4;

	localparam logic [1:0] ST_UNKNOWN = 2'd0;
	localparam logic [1:0] ST_ONLINE  = 2'd1;

	localparam logic [1:0] KIND_STANDARD  = 2'd0;
	localparam logic [1:0] KIND_OPEN      = 2'd1;
	localparam logic [1:0] KIND_UNIVERSAL = 2'd2;
	localparam logic [1:0] KIND_RESERVED  = 2'd3;

	typedef enum logic [2:0] {
		OP_UPDATE,
		OP_REMOVE,
		OP_QUERY,
		OP_FIND,
		OP_LIST
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] node;
		logic [1:0] kind;
		logic [1:0] state;
		logic       in_table;
	} cmd_t;

	typedef struct packed {
		logic       found;
		logic       direct;
		logic [5:0] node;
		logic [1:0] kind;
		logic [1:0] state;
		logic       last;
	} res_t;
endpackage

// ===== rtl/relay_peer_selector_top.sv =====
// top level of the relay peer selector
//
//  channel   direction  handshake      payload
//  request   in         push / full    cmd node node_kind link_state
//  result    out        pop / empty    found direct result_node result_kind queried_state last
//
// update and remove are done in the back end as they are popped; query reads the table, then answers
// find and list scan the table one entry a cycle over min(NODE_COUNT, 64) entries, unless a list stalls
// the table read port sets the scan rate; list stalls while a listed node waits and the result queue is full
// reset clears the table at once through per-entry valid bits
// the request queue lets new requests in while a scan runs
module relay_peer_selector_top #(
	parameter int NODE_COUNT  = rps_pkg::NODE_COUNT_DEF,
	parameter int QUEUE_DEPTH = rps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] cmd,
	input  logic [5:0] node,
	input  logic [1:0] node_kind,
	input  logic [1:0] link_state,
	input  logic       pop,
	output logic       empty,
	output logic       found,
	output logic       direct,
	output logic [5:0] result_node,
	output logic [1:0] result_kind,
	output logic [1:0] queried_state,
	output logic       last
);
	import rps_pkg::*;

	logic cq_push;
	logic cq_full;
	logic cq_pop;
	logic cq_empty;
	cmd_t cq_din;
	cmd_t cq_dout;
	logic rq_push;
	logic rq_full;
	res_t rq_din;
	res_t rq_dout;

	rps_front #(
		.NODE_COUNT(NODE_COUNT)
	) u_front (
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.node      (node),
		.node_kind (node_kind),
		.link_state(link_state),
		.q_full    (cq_full),
		.q_push    (cq_push),
		.q_item    (cq_din)
	);

	rps_fifo #(
		.item_t(cmd_t),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cq_push),
		.din   (cq_din),
		.full  (cq_full),
		.pop   (cq_pop),
		.dout  (cq_dout),
		.empty (cq_empty)
	);

	rps_back #(
		.NODE_COUNT(NODE_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cq_empty),
		.cmd_pop  (cq_pop),
		.cmd_item (cq_dout),
		.out_full (rq_full),
		.out_push (rq_push),
		.out_item (rq_din)
	);

	rps_fifo #(
		.item_t(res_t),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rq_push),
		.din   (rq_din),
		.full  (rq_full),
		.pop   (pop),
		.dout  (rq_dout),
		.empty (empty)
	);

	assign found         = rq_dout.found;
	assign direct        = rq_dout.direct;
	assign result_node   = rq_dout.node;
	assign result_kind   = rq_dout.kind;
	assign queried_state = rq_dout.state;
	assign last          = rq_dout.last;
endmodule

// ===== rtl/rps_fifo.sv =====
// small queue built from registers, used for requests and for results
`include "assert_macros.svh"
module rps_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = rps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	output logic  full,
	input  logic  pop,
	output item_t dout,
	output logic  empty
);
	import rps_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t           entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	`ASSERT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CW'(DEPTH))
endmodule

// ===== rtl/rps_front.sv =====
// front end: decodes and classifies incoming requests
module rps_front #(
	parameter int NODE_COUNT = rps_pkg::NODE_COUNT_DEF
) (
	input  logic          push,
	output logic          full,
	input  logic [2:0]    cmd,
	input  logic [5:0]    node,
	input  logic [1:0]    node_kind,
	input  logic [1:0]    link_state,
	input  logic          q_full,
	output logic          q_push,
	output rps_pkg::cmd_t q_item
);
	import rps_pkg::*;

	logic code_ok;

	always_comb begin
		q_item.node     = node;
		q_item.kind     = (node_kind == KIND_RESERVED) ? KIND_STANDARD : node_kind;
		q_item.state    = link_state;
		q_item.in_table = (int'(node) < NODE_COUNT);
		code_ok         = 1'b1;
		unique case (cmd)
			CMD_UPDATE: begin
				q_item.op = OP_UPDATE;
			end
			CMD_REMOVE: begin
				q_item.op = OP_REMOVE;
			end
			CMD_QUERY: begin
				q_item.op = OP_QUERY;
			end
			CMD_FIND: begin
				q_item.op = OP_FIND;
			end
			CMD_LIST: begin
				q_item.op = OP_LIST;
			end
			default: begin
				// unused codes are taken and dropped
				q_item.op = OP_UPDATE;
				code_ok   = 1'b0;
			end
		endcase
	end

	assign full   = q_full;
	assign q_push = push && !q_full && code_ok;
endmodule

// ===== rtl/rps_back.sv =====
// back end: node table and scan sequencer
`include "assert_macros.svh"
module rps_back #(
	parameter int NODE_COUNT = rps_pkg::NODE_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  rps_pkg::cmd_t cmd_item,
	input  logic          out_full,
	output logic          out_push,
	output rps_pkg::res_t out_item
);
	import rps_pkg::*;

	localparam int DEPTH = (NODE_COUNT < MAX_NODES) ? NODE_COUNT : MAX_NODES;
	localparam int IW    = $clog2(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_QUERY,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] state;
	} entry_t;

	entry_t          table_mem [DEPTH];
	logic [DEPTH-1:0] valid_q;

	state_t          state_q;
	cmd_t            cur_q;
	logic [IW-1:0]   idx_s1;
	entry_t          rd_data_s1;
	logic            rd_valid_s1;
	logic [1:0]      src_st_q;
	logic            have_uni_q;
	logic [5:0]      uni_idx_q;
	logic            have_open_q;
	logic [5:0]      open_idx_q;
	res_t            pend_q;
	logic            pend_vld_q;

	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic            clr_en;
	logic [1:0]      ent_st;
	logic [1:0]      ent_kind;
	logic [5:0]      ent_node;
	logic            ent_online;
	logic            is_src;
	logic            adv;
	logic            scan_hold;

	assign ent_st     = rd_valid_s1 ? rd_data_s1.state : ST_UNKNOWN;
	assign ent_kind   = rd_valid_s1 ? rd_data_s1.kind : KIND_STANDARD;
	assign ent_node   = 6'(idx_s1);
	assign ent_online = (ent_st == ST_ONLINE);
	assign is_src     = (ent_node == cur_q.node);
	// a listed node waits until the next one shows whether it is the last
	assign adv = !(state_q == S_SCAN && cur_q.op == OP_LIST && ent_online
		&& pend_vld_q && out_full);
	assign scan_hold  = (state_q == S_SCAN) && !adv;

	always_comb begin
		cmd_pop  = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		clr_en   = 1'b0;
		out_push = 1'b0;
		out_item = '0;
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					unique case (cmd_item.op)
						OP_UPDATE: begin
							wr_en = cmd_item.in_table;
						end
						OP_REMOVE: begin
							clr_en = cmd_item.in_table;
						end
						OP_QUERY: begin
							rd_en   = 1'b1;
							rd_addr = cmd_item.node[IW-1:0];
						end
						default: begin
							rd_en = 1'b1;
						end
					endcase
				end
			end
			S_QUERY: begin
				out_push       = !out_full;
				out_item.node  = cur_q.node;
				out_item.kind  = KIND_STANDARD;
				out_item.state = cur_q.in_table ? ent_st : ST_UNKNOWN;
				out_item.last  = 1'b1;
			end
			S_SCAN: begin
				if (adv && idx_s1 != LAST_IDX) begin
					rd_en   = 1'b1;
					rd_addr = idx_s1 + 1'b1;
				end
				if (cur_q.op == OP_LIST && ent_online && pend_vld_q) begin
					out_push = !out_full;
					out_item = pend_q;
				end
			end
			S_DONE: begin
				out_push = !out_full;
				if (cur_q.op == OP_LIST) begin
					if (pend_vld_q) begin
						out_item      = pend_q;
						out_item.last = 1'b1;
					end else begin
						out_item.last = 1'b1;
					end
				end else begin
					out_item.state = src_st_q;
					out_item.last  = 1'b1;
					priority if (src_st_q == ST_ONLINE) begin
						out_item.found  = 1'b1;
						out_item.direct = 1'b1;
					end else if (have_uni_q) begin
						out_item.found = 1'b1;
						out_item.node  = uni_idx_q;
						out_item.kind  = KIND_UNIVERSAL;
					end else if (have_open_q) begin
						out_item.found = 1'b1;
						out_item.node  = open_idx_q;
						out_item.kind  = KIND_OPEN;
					end else begin
						out_item.found = 1'b0;
					end
				end
			end
			default: begin
				out_item = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[cmd_item.node[IW-1:0]] <= '{kind: cmd_item.kind, state: cmd_item.state};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= table_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[cmd_item.node[IW-1:0]] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[cmd_item.node[IW-1:0]] <= 1'b0;
			end
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			idx_s1      <= '0;
			src_st_q    <= ST_UNKNOWN;
			have_uni_q  <= 1'b0;
			uni_idx_q   <= '0;
			have_open_q <= 1'b0;
			open_idx_q  <= '0;
			pend_q      <= '0;
			pend_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						cur_q <= cmd_item;
						unique case (cmd_item.op)
							OP_QUERY: begin
								state_q <= S_QUERY;
							end
							OP_FIND, OP_LIST: begin
								idx_s1      <= '0;
								src_st_q    <= ST_UNKNOWN;
								have_uni_q  <= 1'b0;
								have_open_q <= 1'b0;
								pend_vld_q  <= 1'b0;
								state_q     <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_QUERY: begin
					if (!out_full) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (adv) begin
						if (cur_q.op == OP_FIND) begin
							if (is_src) begin
								src_st_q <= ent_st;
							end
							if (ent_online && !is_src) begin
								if (ent_kind == KIND_UNIVERSAL && !have_uni_q) begin
									have_uni_q <= 1'b1;
									uni_idx_q  <= ent_node;
								end
								if (ent_kind == KIND_OPEN && !have_open_q) begin
									have_open_q <= 1'b1;
									open_idx_q  <= ent_node;
								end
							end
						end else if (ent_online) begin
							pend_q     <= '{found: 1'b1, direct: 1'b0, node: ent_node,
								kind: ent_kind, state: ST_ONLINE, last: 1'b0};
							pend_vld_q <= 1'b1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= S_DONE;
						end else begin
							idx_s1 <= idx_s1 + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (!out_full) begin
						pend_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_PROP(a_push_room, clk, arst_n, out_push |-> !out_full)
	`ASSERT_PROP(a_stall_hold, clk, arst_n, scan_hold |=> state_q == S_SCAN && $stable({idx_s1, rd_data_s1}))
	`ASSERT_PROP(a_pend_list, clk, arst_n, pend_vld_q |-> cur_q.op == OP_LIST)
endmodule

// ===== dv/rps_route_checker.sv =====
// checker for the relay peer selector: predicts routes and listings, compares results
`timescale 1ns / 100ps

module rps_route_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [2:0] cmd,
	input  logic [5:0] node,
	input  logic [1:0] node_kind,
	input  logic [1:0] link_state,
	input  logic       pop,
	input  logic       empty,
	input  logic       found,
	input  logic       direct,
	input  logic [5:0] result_node,
	input  logic [1:0] result_kind,
	input  logic [1:0] queried_state,
	input  logic       last,
	output int         fails,
	output int         pending,
	output int         checked
);
	import rps_pkg::*;

	logic [1:0] link_tbl [MAX_NODES];
	logic [1:0] kind_tbl [MAX_NODES];
	res_t       route_q [$];

	function automatic res_t mk_res(logic f, logic d, logic [5:0] n, logic [1:0] k,
			logic [1:0] s, logic l);
		res_t r;
		r.found  = f;
		r.direct = d;
		r.node   = n;
		r.kind   = k;
		r.state  = s;
		r.last   = l;
		return r;
	endfunction

	task automatic expect_res(res_t r);
		route_q = {route_q, r};
	endtask

	task automatic predict_request(logic [2:0] c, logic [5:0] n, logic [1:0] k,
			logic [1:0] s);
		int         online_cnt;
		int         seen;
		bit         have_uni;
		bit         have_open;
		logic [5:0] uni_idx;
		logic [5:0] open_idx;
		online_cnt = 0;
		seen       = 0;
		have_uni   = 1'b0;
		have_open  = 1'b0;
		uni_idx    = '0;
		open_idx   = '0;
		case (c)
			CMD_UPDATE: begin
				link_tbl[n] = s;
				kind_tbl[n] = (k == KIND_RESERVED) ? KIND_STANDARD : k;
			end
			CMD_REMOVE: begin
				link_tbl[n] = ST_UNKNOWN;
				kind_tbl[n] = KIND_STANDARD;
			end
			CMD_QUERY: begin
				expect_res(mk_res(1'b0, 1'b0, n, KIND_STANDARD, link_tbl[n], 1'b1));
			end
			CMD_FIND: begin
				if (link_tbl[n] == ST_ONLINE) begin
					expect_res(mk_res(1'b1, 1'b1, '0, KIND_STANDARD, ST_ONLINE, 1'b1));
				end else begin
					for (int i = 0; i < MAX_NODES; i++) begin
						if (i != n && link_tbl[i] == ST_ONLINE) begin
							if (kind_tbl[i] == KIND_UNIVERSAL && !have_uni) begin
								have_uni = 1'b1;
								uni_idx  = i[5:0];
							end else if (kind_tbl[i] == KIND_OPEN && !have_open) begin
								have_open = 1'b1;
								open_idx  = i[5:0];
							end
						end
					end
					if (have_uni)
						expect_res(mk_res(1'b1, 1'b0, uni_idx, KIND_UNIVERSAL,
							link_tbl[n], 1'b1));
					else if (have_open)
						expect_res(mk_res(1'b1, 1'b0, open_idx, KIND_OPEN,
							link_tbl[n], 1'b1));
					else
						expect_res(mk_res(1'b0, 1'b0, '0, KIND_STANDARD,
							link_tbl[n], 1'b1));
				end
			end
			CMD_LIST: begin
				for (int i = 0; i < MAX_NODES; i++)
					if (link_tbl[i] == ST_ONLINE)
						online_cnt++;
				if (online_cnt == 0) begin
					expect_res(mk_res(1'b0, 1'b0, '0, KIND_STANDARD, ST_UNKNOWN, 1'b1));
				end else begin
					for (int i = 0; i < MAX_NODES; i++) begin
						if (link_tbl[i] == ST_ONLINE) begin
							seen++;
							expect_res(mk_res(1'b1, 1'b0, i[5:0], kind_tbl[i],
								ST_ONLINE, seen == online_cnt));
						end
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic cmp_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic check_result();
		res_t exp_res;
		if (route_q.size() == 0) begin
			$error("result with no request pending: result_node %0d", result_node);
			fails++;
		end else begin
			exp_res = route_q.pop_front();
			cmp_field("found", exp_res.found, found);
			cmp_field("direct", exp_res.direct, direct);
			cmp_field("result_node", exp_res.node, result_node);
			cmp_field("result_kind", exp_res.kind, result_kind);
			cmp_field("queried_state", exp_res.state, queried_state);
			cmp_field("last", exp_res.last, last);
			checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				link_tbl[i] = ST_UNKNOWN;
				kind_tbl[i] = KIND_STANDARD;
			end
			route_q.delete();
			fails   = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				predict_request(cmd, node, node_kind, link_state);
			pending = route_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the relay peer selector: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_top;
	import rps_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
	localparam logic [1:0] ST_OFFLINE     = 2'd2;
	localparam logic [1:0] ST_OFFLINE_ALT = 2'd3;
	localparam int RANDOM_ITEMS = 130;
	localparam int CALM_AFTER   = 100;
	localparam int DRAIN_CYCLES = 80;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       push       = 1'b0;
	logic       full;
	logic [2:0] cmd        = CMD_QUERY;
	logic [5:0] node       = '0;
	logic [1:0] node_kind  = KIND_STANDARD;
	logic [1:0] link_state = ST_UNKNOWN;
	logic       pop        = 1'b0;
	logic       empty;
	logic       found;
	logic       direct;
	logic [5:0] result_node;
	logic [1:0] result_kind;
	logic [1:0] queried_state;
	logic       last;

	int fails;
	int pending;
	int checked;
	bit calm = 1'b0;
	int n_sent = 0;
	int n_find = 0;
	int n_list = 0;
	int n_query = 0;
	int counted;
	int lo;
	int hi;
	int width;
	int steps;
	int pick;

	relay_peer_selector_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.node         (node),
		.node_kind    (node_kind),
		.link_state   (link_state),
		.pop          (pop),
		.empty        (empty),
		.found        (found),
		.direct       (direct),
		.result_node  (result_node),
		.result_kind  (result_kind),
		.queried_state(queried_state),
		.last         (last)
	);

	rps_route_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.node         (node),
		.node_kind    (node_kind),
		.link_state   (link_state),
		.pop          (pop),
		.empty        (empty),
		.found        (found),
		.direct       (direct),
		.result_node  (result_node),
		.result_kind  (result_kind),
		.queried_state(queried_state),
		.last         (last),
		.fails        (fails),
		.pending      (pending),
		.checked      (checked)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send(logic [2:0] c, logic [5:0] n, logic [1:0] k, logic [1:0] s);
		push       <= 1'b1;
		cmd        <= c;
		node       <= n;
		node_kind  <= k;
		link_state <= s;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
		n_sent++;
		if (c == CMD_FIND)
			n_find++;
		else if (c == CMD_LIST)
			n_list++;
		else if (c == CMD_QUERY)
			n_query++;
	endtask

	task automatic rest(int cycles);
		push <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic maybe_rest();
		if (!calm && $urandom_range(0, 4) == 0)
			rest($urandom_range(1, 9));
	endtask

	function automatic logic [5:0] pick_node(int wlo, int whi);
		if ($urandom_range(0, 1))
			return 6'($urandom_range(0, 63));
		return 6'($urandom_range(wlo, whi));
	endfunction

	function automatic logic [1:0] pick_state();
		if ($urandom_range(0, 1))
			return ST_ONLINE;
		return 2'($urandom_range(0, 3));
	endfunction

	// result side: random stall bursts until the calm tail
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				pop <= 1'b0;
				stall = $urandom_range(1, 9) - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: list marker, unknown query, find with no relay
		send(CMD_LIST, 6'd0, KIND_STANDARD, ST_UNKNOWN);
		send(CMD_QUERY, 6'd0, KIND_STANDARD, ST_UNKNOWN);
		maybe_rest();
		send(CMD_FIND, 6'd63, KIND_STANDARD, ST_UNKNOWN);
		send(CMD_UPDATE, 6'd63, KIND_UNIVERSAL, ST_ONLINE);
		send(CMD_UPDATE, 6'd0, KIND_OPEN, ST_ONLINE);
		maybe_rest();
		send(CMD_UPDATE, 6'd5, KIND_RESERVED, ST_ONLINE);
		send(CMD_UPDATE, 6'd10, KIND_OPEN, ST_OFFLINE);
		send(CMD_UPDATE, 6'd20, KIND_UNIVERSAL, ST_OFFLINE_ALT);
		send(CMD_QUERY, 6'd63, KIND_RESERVED, ST_OFFLINE_ALT);
		send(CMD_QUERY, 6'd10, KIND_STANDARD, ST_UNKNOWN);
		maybe_rest();
		send(CMD_QUERY, 6'd20, KIND_STANDARD, ST_UNKNOWN);
		// direct route, then universal over open
		send(CMD_FIND, 6'd63, KIND_STANDARD, ST_UNKNOWN);
		send(CMD_FIND, 6'd1, KIND_STANDARD, ST_UNKNOWN);
		send(CMD_UPDATE, 6'd63, KIND_UNIVERSAL, ST_UNKNOWN);
		// only open relay left
		send(CMD_FIND, 6'd1, KIND_STANDARD, ST_UNKNOWN);
		send(CMD_FIND, 6'd0, KIND_STANDARD, ST_UNKNOWN);
		send(CMD_LIST, 6'd63, KIND_RESERVED, ST_OFFLINE_ALT);
		maybe_rest();
		send(CMD_REMOVE, 6'd0, KIND_RESERVED, ST_OFFLINE_ALT);
		send(CMD_REMOVE, 6'd5, KIND_STANDARD, ST_UNKNOWN);
		send(CMD_LIST, 6'd0, KIND_STANDARD, ST_UNKNOWN);
		send(CMD_SPARE_LO, 6'd63, KIND_RESERVED, ST_OFFLINE_ALT);
		send(CMD_SPARE_MID, 6'd1, KIND_OPEN, ST_ONLINE);
		send(CMD_SPARE_HI, 6'd63, KIND_RESERVED, ST_OFFLINE_ALT);
		send(CMD_UPDATE, 6'd63, KIND_RESERVED, ST_OFFLINE_ALT);
		send(CMD_FIND, 6'd2, KIND_STANDARD, ST_UNKNOWN);

		// hold off until every pending result is drained
		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		// random part in node windows so lists and routes stay interesting
		counted = 0;
		lo = 0;
		hi = 7;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 1)) begin
				for (int i = lo; i <= hi; i++) begin
					send(CMD_REMOVE, 6'(i), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
					counted++;
				end
			end
			width = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(2, 12);
			lo = $urandom_range(0, 64 - width);
			hi = lo + width - 1;
			steps = $urandom_range(8, 24);
			repeat (steps) begin
				if (counted >= CALM_AFTER)
					calm = 1'b1;
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					send(CMD_UPDATE, 6'($urandom_range(lo, hi)), 2'($urandom_range(0, 3)),
						pick_state());
					counted++;
				end else if (pick < 50) begin
					send(CMD_REMOVE, 6'($urandom_range(lo, hi)), 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)));
					counted++;
				end else if (pick < 65) begin
					send(CMD_QUERY, pick_node(lo, hi), 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)));
					counted++;
				end else if (pick < 85) begin
					send(CMD_FIND, pick_node(lo, hi), 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)));
					counted++;
				end else if (pick < 96) begin
					send(CMD_LIST, 6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
						2'($urandom_range(0, 3)));
					counted++;
				end else begin
					send(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 6'($urandom_range(0, 63)),
						2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
				end
				maybe_rest();
			end
		end

		push <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("run: %0d requests sent, %0d finds, %0d lists, %0d queries",
			n_sent, n_find, n_list, n_query);
		$display("run: %0d results checked, stalls on both sides, calm tail at the end",
			checked);
		if (fails == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== relay_peer_selector_top.f =====
+incdir+rtl
rtl/rps_pkg.sv
rtl/rps_fifo.sv
rtl/rps_front.sv
rtl/rps_back.sv
rtl/relay_peer_selector_top.sv
dv/rps_route_checker.sv
dv/tb_top.sv
